// File: hw/rtl/sofnp_pkg.sv
package sofnp_pkg;

   // field and internal widths
   localparam int COUNT_W = 11;                  // prime_count
   localparam int SUM_W   = 24;                  // prime_sum
   localparam int CAND_W  = 14;                  // candidates up to 8162
   localparam int DIV_W   = 7;                   // trial divisors up to 91
   localparam int STEP_W  = 4;                   // remainder step counter, holds CAND_W

   // padded stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // controller -> datapath commands
   typedef struct packed {
      logic init;         // load count, clear sum and found, candidate to 1
      logic trial_init;   // divisor to 2, divisor squared to 4
      logic div_init;     // start a remainder of candidate by divisor
      logic div_step;     // one restoring remainder step
      logic next_div;     // move to the next divisor
      logic take_prime;   // add candidate to the sum
      logic next_cand;    // move to the next candidate
      logic publish;      // copy the sum into the output register
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic all_found;    // found count has reached the wanted count
      logic cand_le1;     // candidate is 0 or 1
      logic sq_gt_cand;   // divisor squared exceeds candidate
      logic div_done;     // remainder complete
      logic rem_zero;     // remainder is zero
   } status_type;

endpackage

// File: hw/rtl/sum_of_first_n_primes_unit.sv
// Sum of the first n primes. Each request transfer carries a count; the
// response transfer carries the sum of that many leading primes (a count of
// zero gives zero, a count above MAX_COUNT is treated as MAX_COUNT). Primes
// are found by trial division of every candidate from 1 upward with
// divisors 2, 3, ... while the divisor squared does not exceed the
// candidate. One request is worked at a time; the remainder unit is a
// bit-serial restoring divider with one step per candidate bit. A new
// request is taken as soon as the previous sum sits in the output
// register, even while that response is still waiting to be taken.
module sum_of_first_n_primes_unit #(
   parameter int MAX_COUNT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sofnp_pkg::REQ_DATA_W-1:0]  req_tdata,   // [10:0] prime_count
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sofnp_pkg::RSP_DATA_W-1:0]  rsp_tdata    // [23:0] prime_sum
);

   sofnp_pkg::cmd_type                cmd;
   sofnp_pkg::status_type             status;
   logic [sofnp_pkg::COUNT_W-1:0]     prime_count;
   logic [sofnp_pkg::SUM_W-1:0]       prime_sum;

   assign prime_count = req_tdata[sofnp_pkg::COUNT_W-1:0];
   assign rsp_tdata   = prime_sum;

   sofnp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sofnp_dpath #(
      .MAX_COUNT (MAX_COUNT)
   ) u_dpath (
      .clock       (clock),
      .prime_count (prime_count),
      .cmd         (cmd),
      .status      (status),
      .prime_sum   (prime_sum)
   );

endmodule

// File: hw/rtl/sofnp_ctrl.sv
module sofnp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  sofnp_pkg::status_type status,
   output sofnp_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TRIAL,
      ST_DIV,
      ST_PUBLISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register may be overwritten when empty or being drained
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.init = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (status.all_found) begin
               state_in = ST_PUBLISH;
            end else if (status.cand_le1) begin
               cmd.next_cand = 1'b1;
            end else begin
               cmd.trial_init = 1'b1;
               state_in       = ST_TRIAL;
            end
         end
         ST_TRIAL: begin
            if (status.sq_gt_cand) begin
               // no divisor found: prime
               cmd.take_prime = 1'b1;
               cmd.next_cand  = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            priority if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else if (status.rem_zero) begin
               cmd.next_cand = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_TRIAL;
            end
         end
         ST_PUBLISH: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/sofnp_dpath.sv
module sofnp_dpath #(
   parameter int MAX_COUNT = 1024
) (
   input  logic                            clock,
   input  logic [sofnp_pkg::COUNT_W-1:0]   prime_count,
   input  sofnp_pkg::cmd_type              cmd,
   output sofnp_pkg::status_type           status,
   output logic [sofnp_pkg::SUM_W-1:0]     prime_sum
);

   localparam int COUNT_W = sofnp_pkg::COUNT_W;
   localparam int SUM_W   = sofnp_pkg::SUM_W;
   localparam int CAND_W  = sofnp_pkg::CAND_W;
   localparam int DIV_W   = sofnp_pkg::DIV_W;
   localparam int STEP_W  = sofnp_pkg::STEP_W;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_COUNT);

   logic [COUNT_W-1:0] want_ff, want_in;
   logic [COUNT_W-1:0] found_ff, found_in;
   logic [CAND_W-1:0]  cand_ff, cand_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [CAND_W-1:0]  sq_ff, sq_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [CAND_W-1:0]  shift_ff, shift_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SUM_W-1:0]   out_ff, out_in;
   logic [DIV_W:0]     trial_rem;
   logic [DIV_W:0]     trial_diff;

   // one restoring remainder step: bring in next dividend bit, subtract if it fits
   assign trial_rem  = {rem_ff, shift_ff[CAND_W-1]};
   assign trial_diff = trial_rem - {1'b0, div_ff};

   always_comb begin
      want_in  = want_ff;
      found_in = found_ff;
      cand_in  = cand_ff;
      total_in = total_ff;
      div_in   = div_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      step_in  = step_ff;
      out_in   = out_ff;

      // item start, count saturates at the limit
      if (cmd.init) begin
         want_in  = (prime_count > COUNT_LIMIT) ? COUNT_LIMIT : prime_count;
         found_in = '0;
         cand_in  = CAND_W'(1);
         total_in = '0;
      end

      // trial divisor sequence, square kept incrementally
      if (cmd.trial_init) begin
         div_in = DIV_W'(2);
         sq_in  = CAND_W'(4);
      end
      if (cmd.next_div) begin
         div_in = div_ff + DIV_W'(1);
         sq_in  = sq_ff + {{(CAND_W-DIV_W-1){1'b0}}, div_ff, 1'b1};
      end

      // remainder unit
      if (cmd.div_init) begin
         rem_in   = '0;
         shift_in = cand_ff;
         step_in  = STEP_W'(CAND_W);
      end
      if (cmd.div_step) begin
         rem_in   = trial_diff[DIV_W] ? trial_rem[DIV_W-1:0] : trial_diff[DIV_W-1:0];
         shift_in = {shift_ff[CAND_W-2:0], 1'b0};
         step_in  = step_ff - STEP_W'(1);
      end

      // accumulation
      if (cmd.take_prime) begin
         total_in = total_ff + {{(SUM_W-CAND_W){1'b0}}, cand_ff};
         found_in = found_ff + COUNT_W'(1);
      end
      if (cmd.next_cand) begin
         cand_in = cand_ff + CAND_W'(1);
      end

      if (cmd.publish) begin
         out_in = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      want_ff  <= want_in;
      found_ff <= found_in;
      cand_ff  <= cand_in;
      total_ff <= total_in;
      div_ff   <= div_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      step_ff  <= step_in;
      out_ff   <= out_in;
   end

   // status to controller
   assign status.all_found  = (found_ff == want_ff);
   assign status.cand_le1   = (cand_ff <= CAND_W'(1));
   assign status.sq_gt_cand = (sq_ff > cand_ff);
   assign status.div_done   = (step_ff == '0);
   assign status.rem_zero   = (rem_ff == '0);

   assign prime_sum = out_ff;

endmodule
